>>> sv/blr_pkg.sv
// Shared types, constants and helper functions of the bilateral Laplacian regularizer.
package blr_pkg;

  // Field and datapath widths.
  localparam int COL_W  = 11;
  localparam int ROW_W  = 13;
  localparam int PIX_W  = 16;
  localparam int WT_W   = 17;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 13;
  localparam int CIDX_W = 8;
  localparam int ACC_W  = 42;
  localparam int PROD_W = 37;
  localparam int Q_W    = 17;
  localparam int SLOT_W = 3;

  // Geometry and scaling constants.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int TABLE_DEPTH   = 256;
  localparam int LINES         = 5;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int ONE_PIXEL     = 32768;
  localparam int ONE_WEIGHT    = 65536;
  localparam longint SUM_DIVISOR = 64'd13107200;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

  // Request types.
  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CRD,
    S_CWAIT,
    S_CHK,
    S_ARD,
    S_BRD,
    S_WA,
    S_WB,
    S_M1,
    S_M2,
    S_DIVST,
    S_DIV,
    S_OUT
  } blr_state_e;

  // Gaussian weight numerator k for window position (ox, oy), gauss = k/100.
  function automatic logic [2:0] gauss_k(input logic [2:0] ox, input logic [2:0] oy);
    logic [2:0] ax;
    logic [2:0] ay;
    ax = (ox > 3'd2) ? (3'd4 - ox) : ox;
    ay = (oy > 3'd2) ? (3'd4 - oy) : oy;
    return 3'd1 + ax + ay;
  endfunction

  // Reduces a value in 0..14 modulo the number of lines.
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (r >= 4'd10) begin
      r = r - 4'd10;
    end else if (r >= 4'd5) begin
      r = r - 4'd5;
    end
    return r[SLOT_W-1:0];
  endfunction

  // Weight table index floor(|a-c|*255/32768), saturated at 255.
  function automatic logic [IDX_W-1:0] weight_idx(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] d;
    logic [23:0]      p;
    d = (a > c) ? (a - c) : (c - a);
    p = {8'd0, d} * 24'd255;
    return (p[23:15] > 9'd255) ? 8'd255 : p[22:15];
  endfunction

endpackage

>>> sv/blr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module blr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/blr_div.sv
// Reciprocal-multiply scaler that turns the accumulated sum into a saturated Q2.15 value.
module blr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [blr_pkg::ACC_W-1:0] acc_i,
  output logic                            done_o,
  output logic signed [blr_pkg::Q_W-1:0]  res_o
);
  import blr_pkg::*;

  // The divisor is 25 * 2^19. The low 19 bits of the magnitude are dropped by a
  // shift and the rest is divided by 25 with a rounded-up reciprocal of 2^25/25.
  // The sum magnitude stays below 2^39, so the shifted value fits in 20 bits,
  // where this multiply gives the exact floor.
  localparam int SHIFT_W   = 19;
  localparam int N_W       = 20;
  localparam int RCP_W     = 21;
  localparam int RCP_SHIFT = 25;
  localparam int MUL_W     = N_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_25 = 21'd1342178;

  logic             s1_q, s1_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [N_W-1:0]   n_q, n_d;
  logic [Q_W-1:0]   quo_q, quo_d;
  logic [ACC_W-1:0] mag;
  logic [MUL_W-1:0] prod;

  // The sign and shifted magnitude are registered on start; the reciprocal product is then registered as the quotient.
  always_comb begin
    s1_d   = start_i;
    done_d = s1_q;
    neg_d  = neg_q;
    n_d    = n_q;
    quo_d  = quo_q;
    mag    = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    prod   = MUL_W'(n_q) * MUL_W'(RCP_25);
    if (start_i) begin
      neg_d = acc_i[ACC_W-1];
      n_d   = mag[SHIFT_W+N_W-1:SHIFT_W];
    end
    if (s1_q) begin
      quo_d = Q_W'(prod[MUL_W-1:RCP_SHIFT]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= s1_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    n_q   <= n_d;
    quo_q <= quo_d;
  end

  // Sign and saturation of the truncated quotient.
  always_comb begin
    if (neg_q) begin
      res_o = (quo_q > Q_W'(65536)) ? -Q_W'(65536) : -$signed(quo_q);
    end else begin
      res_o = (quo_q > Q_W'(65535)) ? Q_W'(65535) : $signed(quo_q);
    end
  end

  assign done_o = done_q;

endmodule

>>> sv/bilateral_laplacian_regularizer_core.sv
// Top level: line store and weight table memories with a read-modify sequencer.
// Each result reads the center pixel, then for each in-frame pair of the 25 window offsets
// reads both pixels, looks up both weights, multiplies and accumulates; the sum is scaled
// and waits for the output transfer. A pixel yields up to 9 results in turn, taking no
// input meanwhile; table items and result-less pixels need no sequencing. Reset clears the
// raster position and restores the registers to 1024 x 1024; memories are not cleared.
module bilateral_laplacian_regularizer_core #(
  parameter int MAX_WIDTH = blr_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [blr_pkg::PIX_W-1:0]        pixel_value_i,
  input  logic [blr_pkg::IDX_W-1:0]        table_index_i,
  input  logic [blr_pkg::WT_W-1:0]         table_weight_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [blr_pkg::Q_W-1:0]   reg_value_o,
  output logic [9:0]                       out_col_o,
  output logic [11:0]                      out_row_o,
  output logic                             run_last_o,
  output logic                             frame_last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [blr_pkg::CIDX_W-1:0]       cfg_index_i,
  input  logic [blr_pkg::CFG_W-1:0]        cfg_data_i
);
  import blr_pkg::*;

  localparam int DEPTH = LINES * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  blr_state_e state_q, state_d;

  logic [COL_W-1:0]  fw_q;
  logic [ROW_W-1:0]  fh_q;
  logic [COL_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SLOT_W-1:0] slot_q;

  logic [COL_W-1:0]  x_q, xlo_q, xhi_q;
  logic [ROW_W-1:0]  y_q, yhi_q;
  logic [SLOT_W-1:0] rslot_q;
  logic              fend_q;
  logic [2:0]        ox_q, oy_q;
  logic [PIX_W-1:0]  c_q, a_q, b_q;
  logic [WT_W-1:0]   wa_q;
  logic [WT_W:0]     sumw_q;
  logic signed [17:0]         diff_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [Q_W-1:0]      res_q;

  logic in_xfer, cfg_xfer, out_xfer;
  logic l_we, w_we;
  logic [AW-1:0]     l_waddr, l_raddr;
  logic [PIX_W-1:0]  l_wdata, l_rdata;
  logic [IDX_W-1:0]  w_raddr;
  logic [WT_W-1:0]   w_wdata, w_rdata;
  logic              div_start, div_done;
  logic signed [Q_W-1:0] div_res;

  logic [1:0]        ad_x, ad_y;
  logic              off_valid, off_last, item_last;
  logic [COL_W-1:0]  xp, xm;
  logic [ROW_W-1:0]  yp, ym;
  logic [SLOT_W-1:0] sp, sm;
  logic              xlast, ylast, xany, yany;
  logic [COL_W-1:0]  xlo_n, xhi_n;
  logic [ROW_W-1:0]  ylo_n, yhi_n;
  logic [1:0]        ydelta;

  function automatic logic [AW-1:0] laddr(input logic [SLOT_W-1:0] s,
                                          input logic [COL_W-1:0] c);
    return AW'(32'(s) * MAX_WIDTH + 32'(c));
  endfunction

  assign in_xfer  = in_valid_i && in_ready_o;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Effective frame size.
  always_comb begin
    if (fw_q == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    if (fh_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(fh_q) > HEIGHT_LIMIT) begin
      h_eff = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = fh_q;
    end
  end

  // Range of results completed by the incoming pixel.
  always_comb begin
    xlast = (col_q == w_eff - COL_W'(1));
    ylast = (row_q == h_eff - ROW_W'(1));
    if (xlast) begin
      xany  = 1'b1;
      xlo_n = (col_q >= COL_W'(2)) ? col_q - COL_W'(2) : '0;
      xhi_n = col_q;
    end else begin
      xany  = (col_q >= COL_W'(2));
      xlo_n = col_q - COL_W'(2);
      xhi_n = col_q - COL_W'(2);
    end
    if (ylast) begin
      yany  = 1'b1;
      ylo_n = (row_q >= ROW_W'(2)) ? row_q - ROW_W'(2) : '0;
      yhi_n = row_q;
    end else begin
      yany  = (row_q >= ROW_W'(2));
      ylo_n = row_q - ROW_W'(2);
      yhi_n = row_q - ROW_W'(2);
    end
    ydelta = 2'(row_q - ylo_n);
  end

  // Offset pair geometry for the current window position.
  always_comb begin
    ad_x = (ox_q >= 3'd2) ? 2'(ox_q - 3'd2) : 2'(3'd2 - ox_q);
    ad_y = (oy_q >= 3'd2) ? 2'(oy_q - 3'd2) : 2'(3'd2 - oy_q);
    off_valid = (x_q >= COL_W'(ad_x)) &&
                (({1'b0, x_q} + (COL_W + 1)'(ad_x)) < {1'b0, w_eff}) &&
                (y_q >= ROW_W'(ad_y)) &&
                (({1'b0, y_q} + (ROW_W + 1)'(ad_y)) < {1'b0, h_eff});
    off_last  = (ox_q == 3'd4) && (oy_q == 3'd4);
    item_last = (x_q == xhi_q) && (y_q == yhi_q);
    xp = x_q + COL_W'(ox_q) - COL_W'(2);
    xm = x_q + COL_W'(2) - COL_W'(ox_q);
    yp = y_q + ROW_W'(oy_q) - ROW_W'(2);
    ym = y_q + ROW_W'(2) - ROW_W'(oy_q);
    sp = slot_mod(4'(rslot_q) + 4'(oy_q) + 4'd3);
    sm = slot_mod(4'(rslot_q) + 4'd7 - 4'(oy_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && req_type_i == REQ_PIXEL && xany && yany) begin
          state_d = S_CRD;
        end
      end
      S_CRD:   state_d = S_CWAIT;
      S_CWAIT: state_d = S_CHK;
      S_CHK: begin
        if (off_valid) begin
          state_d = S_ARD;
        end else if (off_last) begin
          state_d = S_DIVST;
        end
      end
      S_ARD: state_d = S_BRD;
      S_BRD: state_d = S_WA;
      S_WA:  state_d = S_WB;
      S_WB:  state_d = S_M1;
      S_M1:  state_d = S_M2;
      S_M2:  state_d = off_last ? S_DIVST : S_CHK;
      S_DIVST: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          state_d = item_last ? S_IDLE : S_CRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and memory port control.
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    div_start   = (state_q == S_DIVST);
    l_we    = in_xfer && (req_type_i == REQ_PIXEL);
    l_waddr = laddr(slot_q, col_q);
    l_wdata = (pixel_value_i > PIX_W'(ONE_PIXEL)) ? PIX_W'(ONE_PIXEL) : pixel_value_i;
    w_we    = in_xfer && (req_type_i == REQ_TABLE);
    w_wdata = (table_weight_i > WT_W'(ONE_WEIGHT)) ? WT_W'(ONE_WEIGHT) : table_weight_i;
    case (state_q)
      S_CHK:   l_raddr = laddr(sp, xp);
      S_ARD:   l_raddr = laddr(sm, xm);
      default: l_raddr = laddr(rslot_q, x_q);
    endcase
    case (state_q)
      S_WA:    w_raddr = weight_idx(b_q, c_q);
      default: w_raddr = weight_idx(a_q, c_q);
    endcase
  end

  // Control registers: state, configuration and raster position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fw_q    <= COL_W'(1024);
      fh_q    <= ROW_W'(1024);
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer && (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT)) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) begin
          fw_q <= cfg_data_i[COL_W-1:0];
        end else begin
          fh_q <= cfg_data_i;
        end
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
      end else if (l_we) begin
        if (xlast) begin
          col_q <= '0;
          if (ylast) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + ROW_W'(1);
            slot_q <= slot_mod(4'(slot_q) + 4'd1);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        xlo_q   <= xlo_n;
        xhi_q   <= xhi_n;
        yhi_q   <= yhi_n;
        x_q     <= xlo_n;
        y_q     <= ylo_n;
        fend_q  <= xlast && ylast;
        rslot_q <= slot_mod(4'(slot_q) + 4'd5 - 4'(ydelta));
      end
      S_CWAIT: begin
        c_q   <= l_rdata;
        acc_q <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
      end
      S_CHK: begin
        if (!off_valid) begin
          if (oy_q == 3'd4) begin
            oy_q <= '0;
            ox_q <= ox_q + 3'd1;
          end else begin
            oy_q <= oy_q + 3'd1;
          end
        end
      end
      S_ARD: a_q <= l_rdata;
      S_BRD: b_q <= l_rdata;
      S_WA:  wa_q <= w_rdata;
      S_WB: begin
        sumw_q <= {1'b0, wa_q} + {1'b0, w_rdata};
        diff_q <= $signed({1'b0, c_q, 1'b0}) - $signed({2'b0, a_q}) - $signed({2'b0, b_q});
      end
      S_M1: prod_q <= $signed({1'b0, sumw_q}) * diff_q;
      S_M2: begin
        acc_q <= acc_q + ACC_W'(prod_q) * $signed({1'b0, gauss_k(ox_q, oy_q)});
        if (oy_q == 3'd4) begin
          oy_q <= '0;
          ox_q <= ox_q + 3'd1;
        end else begin
          oy_q <= oy_q + 3'd1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_q <= div_res;
        end
      end
      S_OUT: begin
        if (out_xfer && !item_last) begin
          if (x_q == xhi_q) begin
            x_q     <= xlo_q;
            y_q     <= y_q + ROW_W'(1);
            rslot_q <= slot_mod(4'(rslot_q) + 4'd1);
          end else begin
            x_q <= x_q + COL_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result payload.
  assign reg_value_o  = res_q;
  assign out_col_o    = x_q[9:0];
  assign out_row_o    = y_q[11:0];
  assign run_last_o   = item_last;
  assign frame_last_o = item_last && fend_q;

  blr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  blr_ram #(
    .WIDTH (WT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (table_index_i),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  blr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .acc_i   (acc_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

endmodule
